### sv/pdf_pkg.sv
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared types, fixed coefficients and command/status words for the
// polyphase decimating FIR.
// ----------------------------------------------------------------------------
package pdf_pkg;

    // Tap index width: covers the widest supported line (64 taps).
    localparam int TAP_IDX_W   = 6;
    localparam int COEF_W      = 16;
    localparam int COEF_COUNT  = 21;
    localparam int COEF_IDX_W  = 5;
    localparam int OUT_W       = 32;
    localparam int FRAC_BITS   = 16;

    typedef logic signed [COEF_W-1:0] coef_t;

    // Signed Q0.16 coefficients (16 fractional bits), row for delay line 0 and row for delay line 1
    localparam coef_t COEF_LINE0 [COEF_COUNT] = '{
        -16'sd706,  16'sd408,    16'sd41,  -16'sd624,  16'sd1278, -16'sd1139,
         16'sd31,   16'sd2298,  -16'sd5002, 16'sd7339, 16'sd24605, 16'sd7339,
        -16'sd5002, 16'sd2298,   16'sd31,  -16'sd1139, 16'sd1278, -16'sd624,
         16'sd41,   16'sd408,   -16'sd706
    };

    localparam coef_t COEF_LINE1 [COEF_COUNT] = '{
        -16'sd121,  16'sd598,   -16'sd709,  16'sd449,  16'sd583,  -16'sd1748,
         16'sd2496, -16'sd1480, -16'sd2580, 16'sd19259, 16'sd19259, -16'sd2580,
        -16'sd1480, 16'sd2496,  -16'sd1748, 16'sd583,  16'sd449,  -16'sd709,
         16'sd598,  -16'sd121,   16'sd0
    };

    // Taps past the defined set weigh zero.
    function automatic coef_t coef_at(input logic line, input logic [TAP_IDX_W-1:0] idx);
        coef_t c;
        c = '0;
        if (idx < TAP_IDX_W'(COEF_COUNT))
        begin
            if (line)
                c = COEF_LINE1[idx[COEF_IDX_W-1:0]];
            else
                c = COEF_LINE0[idx[COEF_IDX_W-1:0]];
        end
        return c;
    endfunction

    // Controller to datapath
    typedef struct packed {
        logic                 wr;      // store the accepted word in its line
        logic                 line;    // delay line in use for this word
        logic                 issue;   // read one tap and start its product
        logic [TAP_IDX_W-1:0] age;     // age of the tap being read
        logic                 finish;  // emit the pair sum and clear it
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;  // products still on their way to the accumulator
        logic out_full;   // result register holds a word that is stalled
    } dp_stat_t;

endpackage

### sv/polyphase_decimating_fir.sv
// ----------------------------------------------------------------------------
// polyphase_decimating_fir
// Polyphase low-pass FIR, decimation by two, Q16.16 samples in and out.
// ----------------------------------------------------------------------------
//
//  channel   valid      stall      payload                         dir
//  -------   --------   ---------  ------------------------------  ---
//  input     in_valid   in_stall   sample_in    [SAMPLE_WIDTH-1:0]  in
//  output    out_valid  out_stall  filtered_out [31:0]              out
//
//  Each word is stored, then stepped tap by tap through the single shared
//  multiplier, and the read/multiply/accumulate pipeline drains before the
//  next word is taken. One result leaves per pair.
//  Reset clears the phase, the accumulator and both fill counts; taps not
//  yet written since reset read as zero, so no clearing pass is needed.
//  A stalled result holds in the output register while the next word is
//  taken; only the close of the following pair waits for it to drain.
//
// ----------------------------------------------------------------------------
module polyphase_decimating_fir #(
    parameter int TAPS_PER_PHASE = 21,
    parameter int SAMPLE_WIDTH   = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [pdf_pkg::OUT_W-1:0]  filtered_out
);

    // command and status between sequencer and datapath
    pdf_pkg::dp_cmd_t  cmd;
    pdf_pkg::dp_stat_t stat;

    // Sequencer: phase bit, tap counter, pair close
    pdf_ctrl #(
        .TAPS_PER_PHASE (TAPS_PER_PHASE)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Datapath: delay-line memory, multiplier, accumulator, result register
    pdf_dp #(
        .TAPS_PER_PHASE (TAPS_PER_PHASE),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .sample_in    (sample_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filtered_out (filtered_out)
    );

endmodule

### sv/pdf_dp.sv
// ----------------------------------------------------------------------------
// pdf_dp
// Datapath: circular delay-line memory, one shared multiplier, pair
// accumulator and result register.
// ----------------------------------------------------------------------------
module pdf_dp #(
    parameter int TAPS_PER_PHASE = 21,
    parameter int SAMPLE_WIDTH   = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pdf_pkg::dp_cmd_t                      cmd,
    output pdf_pkg::dp_stat_t                     stat,
    input  logic signed [SAMPLE_WIDTH-1:0]        sample_in,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [pdf_pkg::OUT_W-1:0]      filtered_out
);

    localparam int PW = (TAPS_PER_PHASE > 1) ? $clog2(TAPS_PER_PHASE) : 1;
    localparam int AW = $clog2(2 * TAPS_PER_PHASE);
    localparam int FW = $clog2(TAPS_PER_PHASE + 1);
    localparam int MW = SAMPLE_WIDTH + pdf_pkg::COEF_W;

    logic signed [SAMPLE_WIDTH-1:0] mem [0:2*TAPS_PER_PHASE-1];

    logic [PW-1:0] wp_reg   [2];
    logic [FW-1:0] fill_reg [2];
    logic [PW-1:0] rp_reg;

    logic                           rd_vld_reg;
    logic                           tap_ok_reg;
    logic signed [SAMPLE_WIDTH-1:0] rd_data_reg;
    pdf_pkg::coef_t                 coef_reg;

    logic                               prod_vld_reg;
    logic signed [pdf_pkg::OUT_W-1:0]   prod_reg;
    logic signed [pdf_pkg::OUT_W-1:0]   prod_next;

    logic signed [pdf_pkg::OUT_W-1:0]   acc_reg;
    logic                               out_valid_reg;
    logic signed [pdf_pkg::OUT_W-1:0]   out_data_reg;

    logic [PW-1:0] wr_pos;
    logic [PW-1:0] rp_dec;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [FW-1:0] fill_cur;

    logic signed [SAMPLE_WIDTH-1:0] mul_a;
    logic signed [MW-1:0]           mul_p;
    logic signed [MW-1:0]           mul_sh;

    // Advance the write pointer of the selected line, wrapping at the line length
    always_comb
    begin
        if (wp_reg[cmd.line] == PW'(TAPS_PER_PHASE - 1))
            wr_pos = '0;
        else
            wr_pos = wp_reg[cmd.line] + 1'b1;

        if (rp_reg == '0)
            rp_dec = PW'(TAPS_PER_PHASE - 1);
        else
            rp_dec = rp_reg - 1'b1;

        wr_addr  = AW'(wr_pos) + (cmd.line ? AW'(TAPS_PER_PHASE) : AW'(0));
        rd_addr  = AW'(rp_reg) + (cmd.line ? AW'(TAPS_PER_PHASE) : AW'(0));
        fill_cur = fill_reg[cmd.line];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            mem[wr_addr] <= sample_in;
        if (cmd.issue)
            rd_data_reg <= mem[rd_addr];
    end

    // Floor the product to 16 fractional bits; keep the low 32 bits
    always_comb
    begin
        mul_a     = tap_ok_reg ? rd_data_reg : '0;
        mul_p     = MW'(mul_a) * MW'(coef_reg);
        mul_sh    = mul_p >>> pdf_pkg::FRAC_BITS;
        prod_next = pdf_pkg::OUT_W'(mul_sh);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
            coef_reg <= pdf_pkg::coef_at(cmd.line, cmd.age);
        if (rd_vld_reg)
            prod_reg <= prod_next;
        if (cmd.finish)
            out_data_reg <= acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg[0]     <= '0;
            wp_reg[1]     <= '0;
            fill_reg[0]   <= '0;
            fill_reg[1]   <= '0;
            rp_reg        <= '0;
            rd_vld_reg    <= 1'b0;
            tap_ok_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
            begin
                wp_reg[cmd.line] <= wr_pos;
                rp_reg           <= wr_pos;
                if (fill_cur != FW'(TAPS_PER_PHASE))
                    fill_reg[cmd.line] <= fill_cur + 1'b1;
            end
            else if (cmd.issue)
            begin
                rp_reg <= rp_dec;
            end

            rd_vld_reg   <= cmd.issue;
            // taps never written since reset read as zero
            tap_ok_reg   <= FW'(cmd.age) < fill_cur;
            prod_vld_reg <= rd_vld_reg;

            if (cmd.finish)
                acc_reg <= '0;
            else if (prod_vld_reg)
                acc_reg <= acc_reg + prod_reg;

            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.pipe_busy = rd_vld_reg | prod_vld_reg;
    assign stat.out_full  = out_valid_reg & out_stall;
    assign out_valid      = out_valid_reg;
    assign filtered_out   = out_data_reg;

`ifndef SYNTHESIS
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (out_valid_reg && acc_reg == '0))
        else $error("pair sum not loaded or accumulator not cleared");

    a_no_acc_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !prod_vld_reg)
        else $error("product still pending when pair sum emitted");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg[0] <= FW'(TAPS_PER_PHASE)) && (fill_reg[1] <= FW'(TAPS_PER_PHASE)))
        else $error("delay line fill count past line length");
`endif

endmodule

### sv/pdf_ctrl.sv
// ----------------------------------------------------------------------------
// pdf_ctrl
// Controller: accepts a word, steps the shared multiplier over the taps of
// its line, waits for the pipeline to drain and closes the pair on its second word.
// ----------------------------------------------------------------------------
module pdf_ctrl #(
    parameter int TAPS_PER_PHASE = 21
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output pdf_pkg::dp_cmd_t   cmd,
    input  pdf_pkg::dp_stat_t  stat
);

    localparam int IW = (TAPS_PER_PHASE > 1) ? $clog2(TAPS_PER_PHASE) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] cnt_reg,   cnt_next;
    logic          phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        in_stall   = 1'b1;

        cmd        = '0;
        // first word of a pair goes to line 1, second to line 0
        cmd.line   = ~phase_reg;
        cmd.age    = pdf_pkg::TAP_IDX_W'(cnt_reg);

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.wr     = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == IW'(TAPS_PER_PHASE - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (!stat.out_full)
                    begin
                        cmd.finish = 1'b1;
                        phase_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_RUN))
        else $error("accepted word did not start a tap sweep");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!stat.pipe_busy && !stat.out_full && phase_reg))
        else $error("pair closed with pipeline busy or result blocked");

    a_phase_flips: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && state_next == ST_IDLE) |=> (phase_reg != $past(phase_reg)))
        else $error("phase did not alternate after a word");
`endif

endmodule

### tb/sv/tb_polyphase_decimating_fir.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyphase_decimating_fir
// Self-checking bench for the decimate-by-two polyphase FIR. It streams
// signed Q16.16 words with random gaps and output stalls, models both
// delay lines and the pair accumulator, and checks every emitted pair sum.
// ----------------------------------------------------------------------------
module tb_polyphase_decimating_fir;

    localparam int TAPS         = 21;
    localparam int SW           = 32;
    // Drain allowance after the last word: two words' worth plus margin.
    localparam int DRAIN_CYCLES = 2 * (TAPS + 4) + 20;
    // Watchdog limit, set well above the slowest legal run.
    localparam int CYCLE_LIMIT  = 500000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [SW-1:0] sample_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [pdf_pkg::OUT_W-1:0] filtered_out;

    // Filter state as the bench sees it
    logic signed [31:0] tap_hist [2][TAPS];
    int                 weight   [2][TAPS];
    logic               phase_odd;
    logic [31:0]        pair_sum;
    logic [31:0]        expected_sums [$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  idle_on     = 1'b1;

    polyphase_decimating_fir #(
        .TAPS_PER_PHASE (TAPS),
        .SAMPLE_WIDTH   (SW)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_in    (sample_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filtered_out (filtered_out)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: end the run as failed once the cycle limit is passed.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        begin
            $display("mismatch @%0d: %s", cycle_count, what);
            error_count = error_count + 1;
        end
    endtask

    // Q16.16 taps: floor of the real coefficient times 2^16.
    // Row 1 feeds the line that takes the first word of each pair.
    task automatic load_weights();
        begin
            weight[0] = '{ -706, 408, 41, -624, 1278, -1139, 31, 2298, -5002, 7339,
                           24605, 7339, -5002, 2298, 31, -1139, 1278, -624, 41, 408,
                           -706 };
            weight[1] = '{ -121, 598, -709, 449, 583, -1748, 2496, -1480, -2580,
                           19259, 19259, -2580, -1480, 2496, -1748, 583, 449, -709,
                           598, -121, 0 };
        end
    endtask

    // Shift one accepted word into its line, add that phase's dot product to
    // the pair sum, and queue the sum when the pair closes.
    task automatic fir_predict_word(input logic signed [31:0] w);
        int          ln;
        int          i;
        longint      prod;
        logic [31:0] partial;
        begin
            ln = phase_odd ? 0 : 1;
            for (i = TAPS - 1; i > 0; i--)
                tap_hist[ln][i] = tap_hist[ln][i - 1];
            tap_hist[ln][0] = w;
            partial = '0;
            for (i = 0; i < TAPS; i++)
            begin
                prod = longint'(tap_hist[ln][i]) * longint'(weight[ln][i]);
                // Arithmetic shift floors toward minus infinity; keep the low
                // 32 bits so every sum wraps.
                partial = partial + 32'(prod >>> 16);
            end
            pair_sum = pair_sum + partial;
            if (phase_odd)
            begin
                expected_sums.push_back(pair_sum);
                pair_sum  = '0;
                phase_odd = 1'b0;
            end
            else
                phase_odd = 1'b1;
        end
    endtask

    // Offer one word at the falling edge and hold it until the block takes it.
    // An optional idle burst goes in front while idling is enabled.
    task automatic send_word(input logic signed [31:0] w);
        int gap;
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 11);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid  <= 1'b1;
            sample_in <= w;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            fir_predict_word(w);
        end
    endtask

    // Output stall: random bursts while idling is enabled.
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 11);
        out_stall <= (stall_left > 0);
    end

    // Compare each accepted result with the oldest pair sum waiting.
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_sums.size() == 0)
                report_mismatch($sformatf("unexpected word %h", filtered_out));
            else
            begin
                want = expected_sums.pop_front();
                if (filtered_out !== want)
                    report_mismatch($sformatf("filtered_out %h, want %h",
                                              filtered_out, want));
            end
        end
    end

    // Full-scale words: drive the products and the pair sum through wrap.
    task automatic test_extremes();
        begin
            send_word(32'sh7FFFFFFF);
            send_word(32'sh7FFFFFFF);
            send_word(32'sh80000000);
            send_word(32'sh80000000);
            send_word(32'sh7FFFFFFF);
            send_word(32'sh80000000);
            send_word(32'sh00000000);
            send_word(32'sh00000000);
        end
    endtask

    // Tiny words: a product of -1 LSB must floor to -1, never round to zero.
    task automatic test_floor_rounding();
        begin
            send_word(-32'sd1);
            send_word(32'sd1);
            send_word(-32'sd1);
            send_word(32'sd1);
        end
    endtask

    // 1.0 followed by zeros walks the coefficient set of the first line,
    // including its zero-weight last tap.
    task automatic test_impulse_response();
        int k;
        begin
            send_word(32'sh00010000);
            for (k = 0; k < 2 * TAPS - 1; k++)
                send_word(32'sh00000000);
        end
    endtask

    function automatic logic signed [31:0] pick_sample();
        logic signed [31:0] v;
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    case ($urandom_range(0, 4))
                        0: v = 32'sh7FFFFFFF;
                        1: v = 32'sh80000000;
                        2: v = -32'sd1;
                        3: v = 32'sd1;
                        default: v = '0;
                    endcase
                end
                1: v = $urandom_range(0, 32'h3FFFF) * ($urandom_range(0, 1) ? 1 : -1);
                2: v = 32'sh7FFF0000 | 32'($urandom_range(0, 16'hFFFF));
                default: v = $urandom();
            endcase
            return v;
        end
    endfunction

    // Random words with idle and stall bursts on both sides.
    task automatic test_random_stream(input int count);
        int k;
        begin
            idle_on = 1'b1;
            for (k = 0; k < count; k++)
                send_word(pick_sample());
        end
    endtask

    // Back-to-back words with the output always ready.
    task automatic test_steady_flow(input int count);
        int k;
        begin
            idle_on = 1'b0;
            for (k = 0; k < count; k++)
                send_word(pick_sample());
        end
    endtask

    // Drop valid, let the pipeline drain, and give the verdict.
    task automatic finish_run();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (expected_sums.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (expected_sums.size() != 0)
                report_mismatch($sformatf("%0d pair sums never arrived",
                                          expected_sums.size()));
            if (error_count == 0)
                $display("[ OK ] regression clean");
            else
                $display("[FAIL] regression broken");
            $finish;
        end
    endtask

    initial
    begin
        int i;
        load_weights();
        for (i = 0; i < TAPS; i++)
        begin
            tap_hist[0][i] = '0;
            tap_hist[1][i] = '0;
        end
        phase_odd = 1'b0;
        pair_sum  = '0;

        // Hold reset, then release it away from the rising edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_floor_rounding();
        test_impulse_response();
        test_random_stream(1020);
        test_steady_flow(200);
        finish_run();
    end

endmodule

### sim.f
sv/pdf_pkg.sv
sv/pdf_dp.sv
sv/pdf_ctrl.sv
sv/polyphase_decimating_fir.sv
tb/sv/tb_polyphase_decimating_fir.sv
